@@ src/local_window_binarizer_unit_defines.svh @@
// Assertion macros used by the binarizer top file
`ifndef LOCAL_WINDOW_BINARIZER_UNIT_DEFINES_SVH
`define LOCAL_WINDOW_BINARIZER_UNIT_DEFINES_SVH
// implication checked at every edge outside reset
`define LWB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication with the consequent checked in the next cycle
`define LWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/lwb_pkg.sv @@
// ----------------------------------------------------------------------------
// lwb_pkg
// Types, constants and helpers of the local window binarizer.
// ----------------------------------------------------------------------------
package lwb_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 8;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;
  localparam logic [2:0] REG_LEVEL  = 3'd4;

  localparam logic [1:0] MODE_MEAN = 2'd0;
  localparam logic [1:0] MODE_MID  = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;
  localparam logic [1:0] MODE_FIX  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_LAST, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic write_px;
    logic check;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic scan_done;
    logic div_done;
  } stat_t;
endpackage

@@ src/lwb_ram.sv @@
// ----------------------------------------------------------------------------
// lwb_ram
// Single-port write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/lwb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lwb_ctrl
// Sequencer: pixel write, readiness check, window scan, divide, emit.
// ----------------------------------------------------------------------------
module lwb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_cmd,
  input  logic           out_busy,
  input  logic           out_stall,
  input  lwb_pkg::stat_t stat,
  output logic           in_stall,
  output lwb_pkg::cmd_t  cmd
);
  lwb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      lwb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.write_px = !in_cmd;
          state_next   = lwb_pkg::ST_CHECK;
        end
      end
      lwb_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.ready) begin
          cmd.scan_start = 1'b1;
          state_next     = lwb_pkg::ST_SCAN;
        end else begin
          state_next = lwb_pkg::ST_IDLE;
        end
      end
      lwb_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = lwb_pkg::ST_LAST;
        end
      end
      lwb_pkg::ST_LAST: begin
        cmd.scan_step = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = lwb_pkg::ST_DIV;
      end
      lwb_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = lwb_pkg::ST_EMIT;
        end
      end
      lwb_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_busy || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = lwb_pkg::ST_IDLE;
        end
      end
      default: state_next = lwb_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ src/lwb_datapath.sv @@
// ----------------------------------------------------------------------------
// lwb_datapath
// Counters, grey line store, window scan unit and restoring divider.
// ----------------------------------------------------------------------------
module lwb_datapath #(
  parameter int MAX_WIDTH  = lwb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lwb_pkg::MAX_RADIUS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lwb_pkg::cmd_t  cmd,
  input  logic [7:0]     blue,
  input  logic [7:0]     green,
  input  logic [7:0]     red,
  input  logic [10:0]    cfg_w,
  input  logic [15:0]    cfg_h,
  input  logic [3:0]     cfg_r,
  input  logic [1:0]     cfg_mode,
  input  logic [7:0]     cfg_level,
  output lwb_pkg::stat_t stat,
  output logic           res_white,
  output logic           res_end
);
  localparam int NSLOT = 2 * MAX_RADIUS + 1;
  localparam int DEPTH = NSLOT * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(NSLOT);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int WW    = $clog2(2 * MAX_RADIUS + 1);
  localparam int SUMW  = 8 + 2 * $clog2(2 * MAX_RADIUS);
  localparam int DVW   = SUMW + 1;

  // effective configuration
  logic [CW:0] w;
  logic [15:0] h;
  logic [RW-1:0] r;
  always_comb begin
    if (cfg_w == '0) begin
      w = (CW+1)'(1);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      w = (CW+1)'(MAX_WIDTH);
    end else begin
      w = (CW+1)'(cfg_w);
    end
    h = (cfg_h == '0) ? 16'd1 : cfg_h;
    if (cfg_r == '0) begin
      r = RW'(1);
    end else if (32'(cfg_r) > MAX_RADIUS) begin
      r = RW'(MAX_RADIUS);
    end else begin
      r = RW'(cfg_r);
    end
  end

  logic [CW:0]   in_col, out_col;
  logic [15:0]   in_row, out_row;
  logic [SW-1:0] in_slot, out_slot;
  logic          in_ahead;

  // grey conversion: /10 by reciprocal multiply (x < 2560)
  logic [11:0] gsum;
  logic [7:0]  grey;
  logic [24:0] gprod;
  assign gsum  = 12'({blue, 1'b0}) + 12'(green) * 12'd7 + 12'(red);
  assign gprod = 25'(gsum) * 25'd6554;
  assign grey  = gprod[23:16];

  logic [CW:0] wcol;
  assign wcol = (in_col < w) ? in_col : w - 1'b1;

  // window scan counters
  logic [WW-1:0] kk, ll;
  logic [SUMW-1:0] sum;
  logic [7:0] mn, mx, gcen;
  logic first_rd, rd_valid;

  logic signed [17:0] krow, lcol;
  logic [15:0] kc;
  logic [CW:0] lc;
  logic [SW-1:0] rslot;
  logic [SW:0]   sdist;
  always_comb begin
    krow = $signed({2'b0, out_row}) - $signed(18'(r)) + $signed(18'(kk));
    lcol = $signed(18'(out_col)) - $signed(18'(r)) + $signed(18'(ll));
    if (krow < 0) begin
      kc = '0;
    end else if (krow > $signed({2'b0, h - 16'd1})) begin
      kc = h - 16'd1;
    end else begin
      kc = krow[15:0];
    end
    if (lcol < 0) begin
      lc = '0;
    end else if (lcol > $signed(18'(w - 1'b1))) begin
      lc = w - 1'b1;
    end else begin
      lc = lcol[CW:0];
    end
    // kc - out_row lies in -r..r-1
    if (kc >= out_row) begin
      sdist = (SW+1)'(out_slot) + (SW+1)'(kc - out_row);
    end else begin
      sdist = (SW+1)'(out_slot) + (SW+1)'(NSLOT) - (SW+1)'(out_row - kc);
    end
    rslot = (sdist >= (SW+1)'(NSLOT)) ? SW'(sdist - (SW+1)'(NSLOT)) : SW'(sdist);
  end

  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  logic [CW:0]   ocol;
  assign ocol  = (out_col < w) ? out_col : w - 1'b1;
  assign waddr = AW'(32'(in_slot) * MAX_WIDTH + 32'(wcol));
  assign raddr = cmd.scan_start ? AW'(32'(out_slot) * MAX_WIDTH + 32'(ocol))
                                : AW'(32'(rslot) * MAX_WIDTH + 32'(lc));

  lwb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(cmd.write_px), .waddr(waddr), .wdata(grey),
    .raddr(raddr), .rdata(rdata)
  );

  logic [WW-1:0] twor;
  assign twor = WW'({r, 1'b0});
  assign stat.scan_done = (kk == twor - 1'b1) && (ll == twor - 1'b1);

  // readiness
  logic [16:0] nr;
  logic [CW+1:0] nc;
  logic [15:0] nrc;
  logic [CW:0] ncc;
  assign nr  = 17'(out_row) + 17'(r) - 17'd1;
  assign nc  = (CW+2)'(out_col) + (CW+2)'(r) - 1'b1;
  assign nrc = (nr > 17'(h - 16'd1)) ? h - 16'd1 : nr[15:0];
  assign ncc = (nc > (CW+2)'(w - 1'b1)) ? w - 1'b1 : nc[CW:0];
  assign stat.ready = in_ahead || (in_row > nrc) || (in_row == nrc && in_col > ncc);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      kk <= '0;
      ll <= '0;
      first_rd <= 1'b1;
      rd_valid <= 1'b0;
      sum <= '0;
      mn <= 8'd255;
      mx <= 8'd0;
    end else if (cmd.scan_step) begin
      first_rd <= 1'b0;
      rd_valid <= 1'b1;
      if (first_rd) begin
        gcen <= rdata;
      end
      if (rd_valid) begin
        sum <= sum + SUMW'(rdata);
        if (rdata < mn) mn <= rdata;
        if (rdata > mx) mx <= rdata;
      end
      if (ll == twor - 1'b1) begin
        ll <= '0;
        kk <= kk + 1'b1;
      end else begin
        ll <= ll + 1'b1;
      end
    end
  end

  // restoring divider: sum / (4 r^2), one quotient bit a cycle
  logic [DVW-1:0] rem;
  logic [SUMW-1:0] quo, dvd;
  logic [SUMW-1:0] dvs;
  logic [$clog2(SUMW+1)-1:0] dcnt;
  logic [SUMW+7:0] fullsum;
  logic [7:0] thr;
  assign fullsum = (SUMW+8)'(sum) + (SUMW+8)'(rdata); // last read arrives now
  assign stat.div_done = (dcnt == '0);
  logic [DVW-1:0] trial;
  assign trial = {rem[DVW-2:0], dvd[SUMW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= SUMW'(fullsum);
      dvs  <= SUMW'(4 * 32'(r) * 32'(r));
      rem  <= '0;
      quo  <= '0;
      dcnt <= ($clog2(SUMW+1))'(SUMW);
    end else if (cmd.div_step && dcnt != '0) begin
      dvd <= {dvd[SUMW-2:0], 1'b0};
      if (trial >= DVW'(dvs)) begin
        rem <= trial - DVW'(dvs);
        quo <= {quo[SUMW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[SUMW-2:0], 1'b0};
      end
      dcnt <= dcnt - 1'b1;
    end
  end

  always_comb begin
    case (cfg_mode)
      lwb_pkg::MODE_MEAN: thr = quo[7:0];
      lwb_pkg::MODE_MID:  thr = 8'((9'(mn) + 9'(mx)) >> 1);
      lwb_pkg::MODE_MIN:  thr = mn;
      lwb_pkg::MODE_FIX:  thr = cfg_level;
      default:            thr = cfg_level;
    endcase
  end
  assign res_white = gcen > thr;
  assign res_end   = (17'(out_row) + 17'd1 >= 17'(h)) && (out_col + 1'b1 >= w);

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0; in_row <= '0; in_slot <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0;
      in_ahead <= 1'b0;
    end else begin
      if (cmd.write_px) begin
        if (in_col + 1'b1 >= w) begin
          in_col  <= '0;
          in_slot <= (in_slot == SW'(NSLOT - 1)) ? '0 : in_slot + 1'b1;
          if (17'(in_row) + 17'd1 >= 17'(h)) begin
            in_row   <= '0;
            in_ahead <= 1'b1;
          end else begin
            in_row <= in_row + 16'd1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cmd.emit) begin
        if (out_col + 1'b1 >= w) begin
          out_col  <= '0;
          out_slot <= (out_slot == SW'(NSLOT - 1)) ? '0 : out_slot + 1'b1;
          if (17'(out_row) + 17'd1 >= 17'(h)) begin
            out_row  <= '0;
            in_ahead <= 1'b0;
          end else begin
            out_row <= out_row + 16'd1;
          end
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end
endmodule

@@ src/local_window_binarizer_unit.sv @@
// ----------------------------------------------------------------------------
// local_window_binarizer_unit
// Adaptive local threshold binarizer over a streamed colour frame.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carries cmd, blue, green, red in raster
// order; cmd high is a drain step that only flushes pending results.
// Output channel: out_valid/out_stall carries is_white and frame_end.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while idle. Registers: width, height, radius, mode, fixed level.
// An item with no result due goes through the readiness check back to idle.
// An item that yields a result runs the window scan (one store read a cycle
// through the single RAM read port), then the bit-serial mean divider, then
// loads the output register.
// The output register frees the pipeline: the next item is accepted while a
// result waits; if the result is still not taken when the next is due, the
// sequencer holds and the input stalls.
// Reset clears counters and control; the line store needs no clearing.
// ----------------------------------------------------------------------------
`include "local_window_binarizer_unit_defines.svh"
module local_window_binarizer_unit #(
  parameter int MAX_WIDTH  = lwb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lwb_pkg::MAX_RADIUS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_white,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [3:0]  window_radius;
  logic [1:0]  threshold_mode;
  logic [7:0]  fixed_level;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 11'd640;
      image_height   <= 16'd480;
      window_radius  <= 4'd2;
      threshold_mode <= lwb_pkg::MODE_MEAN;
      fixed_level    <= 8'd90;
    end else if (cfg_valid) begin
      case (cfg_index)
        lwb_pkg::REG_WIDTH:  image_width    <= cfg_data[10:0];
        lwb_pkg::REG_HEIGHT: image_height   <= cfg_data;
        lwb_pkg::REG_RADIUS: window_radius  <= cfg_data[3:0];
        lwb_pkg::REG_MODE:   threshold_mode <= cfg_data[1:0];
        lwb_pkg::REG_LEVEL:  fixed_level    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  lwb_pkg::cmd_t  ctl;
  lwb_pkg::stat_t stat;
  logic res_white, res_end;

  lwb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_cmd(cmd),
    .out_busy(out_valid), .out_stall(out_stall), .stat(stat),
    .in_stall(in_stall), .cmd(ctl)
  );

  lwb_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk(clk), .rst(rst), .cmd(ctl), .blue(blue), .green(green), .red(red),
    .cfg_w(image_width), .cfg_h(image_height), .cfg_r(window_radius),
    .cfg_mode(threshold_mode), .cfg_level(fixed_level), .stat(stat),
    .res_white(res_white), .res_end(res_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      is_white  <= res_white;
      frame_end <= res_end;
    end
  end

  `LWB_ASSERT_IMPL(a_emit_free, ctl.emit, !out_valid || !out_stall)
  `LWB_ASSERT_NEXT(a_emit_valid, ctl.emit, out_valid)
  `LWB_ASSERT_IMPL(a_no_write_busy, ctl.write_px, !in_stall && in_valid)
endmodule
